>>> rtl/core/tmt_pkg.sv
// Shared constants, types and helpers of the timer slot table.
`timescale 1ns / 1ps
package tmt_pkg;

  // Table geometry
  localparam int SLOTS   = 16;
  localparam int ID_BITS = 16;
  localparam int CNT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int DT_W   = 16;
  localparam int TID_W  = 16;
  localparam int IVAL_W = 31;
  localparam int EL_W   = 32;
  localparam int STAT_W = 3;
  localparam int RID_W  = 16;
  localparam int CMP_W  = (ID_BITS > TID_W) ? ID_BITS : TID_W;
  localparam int XID_W  = (CMP_W > RID_W) ? CMP_W : RID_W;

  // Request function codes
  localparam logic [FUNC_W-1:0] FN_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REG   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UNREG = 2'd2;
  localparam logic [FUNC_W-1:0] FN_SET   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_FIRED      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOFIRE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_REGISTERED = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STAT_W-1:0] ST_DONE       = 3'd4;

  // Latched request, broadcast to every cell
  typedef struct packed {
    logic               is_reg;
    logic [DT_W-1:0]    delta;
    logic [ID_BITS-1:0] new_id;
    logic [TID_W-1:0]   tid;
    logic [IVAL_W-1:0]  interval;
  } tmt_cmd_t;

  // Per-cycle strobes from the controller
  typedef struct packed {
    logic upd;
    logic shift;
    logic unreg;
  } tmt_ctl_t;

  // Fire report travelling down the chain
  typedef struct packed {
    logic               flag;
    logic [ID_BITS-1:0] id;
  } tmt_rep_t;

  // Slot ident against a request id; id bits above ID_BITS never match
  function automatic logic id_match(logic [ID_BITS-1:0] ident, logic [TID_W-1:0] tid);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    a = CMP_W'(ident);
    b = CMP_W'(tid);
    return a == b;
  endfunction

  // Slot ident as a result id
  function automatic logic [RID_W-1:0] id_to_rid(logic [ID_BITS-1:0] ident);
    logic [XID_W-1:0] x;
    x = XID_W'(ident);
    return x[RID_W-1:0];
  endfunction

endpackage

>>> rtl/core/tmt_if.sv
// Request and response channel interfaces of the timer slot table.
`timescale 1ns / 1ps
interface tmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] delta_time;
  logic [15:0] timer_id;
  logic [30:0] new_interval;

  modport source (output valid, func, delta_time, timer_id, new_interval, input ready);
  modport sink   (input valid, func, delta_time, timer_id, new_interval, output ready);
endinterface

interface tmt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] result_id;
  logic        last;

  modport source (output valid, status, result_id, last, input ready);
  modport sink   (input valid, status, result_id, last, output ready);
endinterface

>>> rtl/core/tmt_cell.sv
// One timer slot: state, tick update, search token stage and fire report stage.
`timescale 1ns / 1ps
module tmt_cell (
  input  logic              clk,
  input  logic              rst,
  input  tmt_pkg::tmt_cmd_t cmd,
  input  tmt_pkg::tmt_ctl_t ctl,
  input  logic              tok_in,
  output logic              tok_out,
  output logic              tok,
  input  tmt_pkg::tmt_rep_t rep_in,
  output tmt_pkg::tmt_rep_t rep_out
);
  import tmt_pkg::*;

  logic               used;
  logic               pending;
  logic [ID_BITS-1:0] ident;
  logic [IVAL_W-1:0]  interval;
  logic [EL_W-1:0]    elapsed;
  tmt_rep_t           rep;

  logic            armed;
  logic [EL_W:0]   sum;
  logic [EL_W-1:0] elapsed_next;
  logic            match;
  logic            hit;

  // Saturating elapsed update
  assign armed        = used && !pending && (interval != '0);
  assign sum          = {1'b0, elapsed} + (EL_W + 1)'(cmd.delta);
  assign elapsed_next = sum[EL_W] ? '1 : sum[EL_W-1:0];

  // Search token: free slot for register, lowest matching slot for set interval
  assign match   = used && id_match(ident, cmd.tid);
  assign hit     = tok && (cmd.is_reg ? !used : match);
  assign tok_out = tok && !hit;
  assign rep_out = rep;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      pending <= 1'b0;
      tok     <= 1'b0;
    end else begin
      tok <= tok_in;
      if (ctl.upd && used && pending) begin
        used    <= 1'b0;
        pending <= 1'b0;
      end
      if (ctl.unreg && match) begin
        pending <= 1'b1;
      end
      if (hit && cmd.is_reg) begin
        used    <= 1'b1;
        pending <= 1'b0;
      end
    end
  end

  // Slot payload and report stage
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      if (armed) begin
        elapsed <= elapsed_next;
      end
      rep.flag <= armed && (elapsed_next > {1'b0, interval});
      rep.id   <= ident;
    end else if (ctl.shift) begin
      rep <= rep_in;
    end
    if (hit) begin
      elapsed <= '0;
      if (cmd.is_reg) begin
        ident    <= cmd.new_id;
        interval <= '0;
      end else begin
        interval <= cmd.interval;
      end
    end
  end

endmodule

>>> rtl/core/multi_slot_software_timer_table.sv
// Top level of the timer slot table: request control, cell chain and result register.
`timescale 1ns / 1ps
// A table of SLOTS timer slots held in a chain of cells, one slot per cell, working on
// one request at a time. A tick updates every slot at once, then the fire reports shift
// down the chain to the head, one slot per cycle save while a fire result waits on a full
// result register, and the final state loads the last result. Register and set interval
// pass a search token along the chain, one cell per cycle, and then load their result.
// Unregister marks every matching slot for removal at the next tick and then loads its
// result. The results of a tick come out in slot order, the last one flagged. A new
// request is taken once the previous one has put its final result into the output
// register.
module multi_slot_software_timer_table (
  input  logic clk,
  input  logic rst,
  tmt_in_if.sink    req,
  tmt_out_if.source rsp
);
  import tmt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_UNREG = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic [ID_BITS-1:0] next_ident;
  tmt_cmd_t           cmd;
  logic               held_v;
  logic [ID_BITS-1:0] held_id;
  logic [STAT_W-1:0]  res_status;
  logic [RID_W-1:0]   res_id;

  logic               o_valid;
  logic [STAT_W-1:0]  o_status;
  logic [RID_W-1:0]   o_id;
  logic               o_last;

  logic               accept;
  logic               start;
  logic               can_load;
  logic               advance;
  logic               cnt_end;
  logic               out_load;
  logic [STAT_W-1:0]  ld_status;
  logic [RID_W-1:0]   ld_id;
  logic               ld_last;
  tmt_ctl_t           ctl;
  tmt_rep_t           head;

  logic [SLOTS:0]     tok_pass;
  logic [SLOTS-1:0]   tok_vec;
  tmt_rep_t           rep [SLOTS+1];

  assign accept    = req.valid && req.ready;
  assign start     = accept && (req.func == FN_REG || req.func == FN_SET);
  assign req.ready = (state == S_IDLE);
  assign can_load  = !o_valid || rsp.ready;
  assign cnt_end   = (cnt == CNT_W'(SLOTS - 1));
  assign head      = rep[0];

  assign rsp.valid     = o_valid;
  assign rsp.status    = o_status;
  assign rsp.result_id = o_id;
  assign rsp.last      = o_last;

  // Cell chain: token runs up from cell 0, reports shift down toward cell 0
  assign tok_pass[0] = start;
  assign rep[SLOTS]  = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tmt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .ctl     (ctl),
      .tok_in  (tok_pass[i]),
      .tok_out (tok_pass[i+1]),
      .tok     (tok_vec[i]),
      .rep_in  (rep[i+1]),
      .rep_out (rep[i])
    );
  end

  // Strobes and result register load
  always_comb begin
    ctl       = '0;
    advance   = 1'b0;
    out_load  = 1'b0;
    ld_status = ST_DONE;
    ld_id     = '0;
    ld_last   = 1'b1;
    unique case (state)
      S_UPD: begin
        ctl.upd = 1'b1;
      end
      S_SHIFT: begin
        advance   = !(head.flag && held_v) || can_load;
        ctl.shift = advance;
        if (advance && head.flag && held_v) begin
          out_load  = 1'b1;
          ld_status = ST_FIRED;
          ld_id     = id_to_rid(held_id);
          ld_last   = 1'b0;
        end
      end
      S_FINAL: begin
        out_load  = can_load;
        ld_status = held_v ? ST_FIRED : ST_NOFIRE;
        ld_id     = held_v ? id_to_rid(held_id) : '0;
      end
      S_UNREG: begin
        ctl.unreg = 1'b1;
      end
      S_EMIT: begin
        out_load  = can_load;
        ld_status = res_status;
        ld_id     = res_id;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      next_ident <= '0;
      held_v     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            unique case (req.func)
              FN_TICK: begin
                held_v <= 1'b0;
                state  <= S_UPD;
              end
              FN_REG: begin
                next_ident <= next_ident + 1'b1;
                state      <= S_WALK;
              end
              FN_UNREG: state <= S_UNREG;
              FN_SET:   state <= S_WALK;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_UPD: begin
          cnt   <= '0;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (advance) begin
            cnt <= cnt + 1'b1;
            if (head.flag) begin
              held_v <= 1'b1;
            end
            if (cnt_end) begin
              state <= S_FINAL;
            end
          end
        end
        S_WALK: begin
          cnt <= cnt + 1'b1;
          if (cnt_end) begin
            state <= S_EMIT;
          end
        end
        S_UNREG: state <= S_EMIT;
        S_FINAL, S_EMIT: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request latch and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.is_reg   <= (req.func == FN_REG);
      cmd.delta    <= req.delta_time;
      cmd.new_id   <= next_ident + 1'b1;
      cmd.tid      <= req.timer_id;
      cmd.interval <= req.new_interval;
    end
    if (state == S_SHIFT && advance && head.flag) begin
      held_id <= head.id;
    end
    if (state == S_WALK && cnt_end) begin
      if (cmd.is_reg) begin
        res_status <= tok_pass[SLOTS] ? ST_FULL : ST_REGISTERED;
        res_id     <= id_to_rid(cmd.new_id);
      end else begin
        res_status <= ST_DONE;
        res_id     <= '0;
      end
    end
    if (state == S_UNREG) begin
      res_status <= ST_DONE;
      res_id     <= '0;
    end
    if (out_load) begin
      o_status <= ld_status;
      o_id     <= ld_id;
      o_last   <= ld_last;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  // The search token is never duplicated
  a_tok_single: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vec))
    else $error("more than one search token in the chain");

  // No token left over while idle
  a_tok_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (tok_vec == '0))
    else $error("search token alive while idle");

  // A held result never overwrites one not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten");

  // Each tick starts with no held fire report
  a_tick_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> !held_v)
    else $error("stale fire report at tick start");

endmodule
